### hw/rtl/crsf_pkg.sv
package crsf_pkg;

    // frame layout constants
    localparam int unsigned STATS_BYTES = 10;
    localparam int unsigned CHAN_BITS   = 11;
    localparam logic [7:0]  CRC_POLY    = 8'hD5;

    // register indexes on the configuration port
    localparam logic [2:0] REG_DEVICE_ADDRESS  = 3'd0;
    localparam logic [2:0] REG_CHANNELS_TYPE   = 3'd1;
    localparam logic [2:0] REG_CHANNELS_LENGTH = 3'd2;
    localparam logic [2:0] REG_STATS_TYPE      = 3'd3;
    localparam logic [2:0] REG_STATS_LENGTH    = 3'd4;

    // register reset values
    localparam logic [7:0] RST_DEVICE_ADDRESS  = 8'd200;
    localparam logic [7:0] RST_CHANNELS_TYPE   = 8'd22;
    localparam logic [5:0] RST_CHANNELS_LENGTH = 6'd24;
    localparam logic [7:0] RST_STATS_TYPE      = 8'd20;
    localparam logic [5:0] RST_STATS_LENGTH    = 6'd12;

    // result kinds
    localparam logic KIND_CHANNEL = 1'b0;
    localparam logic KIND_STATS   = 1'b1;

    // parser phases
    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_LEN     = 5'b00010,
        PH_TYPE    = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_CRC     = 5'b10000
    } t_phase;

    // configuration registers as seen by the parser
    typedef struct packed {
        logic [7:0] device_address;
        logic [7:0] channels_type;
        logic [5:0] channels_length;
        logic [7:0] stats_type;
        logic [5:0] stats_length;
    } t_cfg;

    // request from parser to emitter
    typedef struct packed {
        logic fire;
        logic kind;
    } t_emit_req;

    // crc-8, msb first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### hw/rtl/crsf_parser.sv
module crsf_parser #(
    parameter int unsigned PAYLOAD_BYTES   = 22,
    parameter int unsigned MAX_FRAME_BYTES = 64,
    parameter int unsigned NUM_CHANNELS    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_rx_byte,
    input  crsf_pkg::t_cfg        i_cfg,
    input  logic                  i_out_busy,
    output logic                  o_stall,
    output crsf_pkg::t_emit_req   o_req,
    output logic [((((NUM_CHANNELS * 11) + 7) / 8 > 10) ?
                   (((NUM_CHANNELS * 11) + 7) / 8) : 10) * 8 - 1 : 0] o_snap
);
    import crsf_pkg::*;

    localparam int unsigned CH_BYTES = (NUM_CHANNELS * CHAN_BITS + 7) / 8;
    localparam int unsigned NEED     = (CH_BYTES > STATS_BYTES) ? CH_BYTES : STATS_BYTES;
    localparam int unsigned SD       = (PAYLOAD_BYTES < NEED) ? PAYLOAD_BYTES : NEED;
    localparam int unsigned IW       = $clog2(SD);

    t_phase     r_phase, n_phase;
    logic [7:0] r_cnt, n_cnt;
    logic [7:0] r_len, n_len;
    logic [7:0] r_type, n_type;
    logic [7:0] r_crc, n_crc;
    logic [7:0] r_store [SD];
    logic       acc;
    logic       chan_hit;
    logic       stat_hit;

    // a byte in the crc phase may start a burst of results
    assign o_stall = (r_phase == PH_CRC) && i_out_busy;
    assign acc     = i_valid && !o_stall;

    assign chan_hit = (r_type == i_cfg.channels_type) &&
                      (r_len == {2'b00, i_cfg.channels_length});
    assign stat_hit = (r_type == i_cfg.stats_type) &&
                      (r_len == {2'b00, i_cfg.stats_length});

    // frame state machine
    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_len      = r_len;
        n_type     = r_type;
        n_crc      = r_crc;
        o_req.fire = 1'b0;
        o_req.kind = chan_hit ? KIND_CHANNEL : KIND_STATS;
        if (acc) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == i_cfg.device_address) begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if ((i_rx_byte < 8'd2) ||
                        ({1'b0, i_rx_byte} > 9'(MAX_FRAME_BYTES - 2))) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_len   = i_rx_byte;
                        n_cnt   = 8'd0;
                        n_crc   = 8'd0;
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_type  = i_rx_byte;
                    n_crc   = crc8_update(8'd0, i_rx_byte);
                    n_phase = (r_len > 8'd2) ? PH_PAYLOAD : PH_CRC;
                end
                PH_PAYLOAD: begin
                    n_crc = crc8_update(r_crc, i_rx_byte);
                    n_cnt = r_cnt + 8'd1;
                    if (({1'b0, r_cnt} + 9'd1) >= ({1'b0, r_len} - 9'd2)) begin
                        n_phase = PH_CRC;
                    end
                end
                PH_CRC: begin
                    o_req.fire = (i_rx_byte == r_crc) && (chan_hit || stat_hit);
                    n_phase    = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_cnt   <= 8'd0;
            r_len   <= 8'd0;
            r_type  <= 8'd0;
            r_crc   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_type  <= n_type;
            r_crc   <= n_crc;
        end
    end

    // payload capture, only the bytes that results can use
    always_ff @(posedge i_clk) begin
        if (acc && (r_phase == PH_PAYLOAD) && (r_cnt < 8'(SD))) begin
            r_store[r_cnt[IW-1:0]] <= i_rx_byte;
        end
    end

    // snapshot for the emitter, bytes not received read as zero
    for (genvar i = 0; i < NEED; i++) begin : g_snap
        if (i < SD) begin : g_have
            assign o_snap[i*8 +: 8] = (9'(i + 2) < {1'b0, r_len}) ? r_store[i] : 8'd0;
        end else begin : g_zero
            assign o_snap[i*8 +: 8] = 8'd0;
        end
    end

endmodule

### hw/rtl/crsf_emitter.sv
module crsf_emitter #(
    parameter int unsigned NUM_CHANNELS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  crsf_pkg::t_emit_req   i_req,
    input  logic [((((NUM_CHANNELS * 11) + 7) / 8 > 10) ?
                   (((NUM_CHANNELS * 11) + 7) / 8) : 10) * 8 - 1 : 0] i_snap,
    input  logic                  i_stall,
    output logic                  o_busy,
    output logic                  o_valid,
    output logic                  o_kind,
    output logic [3:0]            o_item_index,
    output logic [10:0]           o_item_value,
    output logic                  o_last
);
    import crsf_pkg::*;

    localparam int unsigned CH_BYTES = (NUM_CHANNELS * CHAN_BITS + 7) / 8;
    localparam int unsigned NEED     = (CH_BYTES > STATS_BYTES) ? CH_BYTES : STATS_BYTES;
    localparam int unsigned SHW      = NEED * 8;

    logic           r_valid, n_valid;
    logic           r_kind, n_kind;
    logic [3:0]     r_idx, n_idx;
    logic [SHW-1:0] r_shift, n_shift;
    logic           last;
    logic           take;

    assign last = (r_kind == KIND_STATS) ? (r_idx == 4'(STATS_BYTES - 1))
                                         : (r_idx == 4'(NUM_CHANNELS - 1));
    assign take = r_valid && !i_stall;

    // walk through the snapshot one result per taken item
    always_comb begin
        n_valid = r_valid;
        n_kind  = r_kind;
        n_idx   = r_idx;
        n_shift = r_shift;
        if (i_req.fire) begin
            n_valid = 1'b1;
            n_kind  = i_req.kind;
            n_idx   = 4'd0;
            n_shift = i_snap;
        end else if (take) begin
            if (last) begin
                n_valid = 1'b0;
            end else begin
                n_idx   = r_idx + 4'd1;
                n_shift = (r_kind == KIND_STATS) ? (r_shift >> 8) : (r_shift >> CHAN_BITS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_kind  <= KIND_CHANNEL;
            r_idx   <= 4'd0;
        end else begin
            r_valid <= n_valid;
            r_kind  <= n_kind;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
    end

    assign o_busy       = r_valid;
    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_item_index = r_idx;
    assign o_item_value = (r_kind == KIND_STATS) ? {3'b000, r_shift[7:0]}
                                                 : r_shift[CHAN_BITS-1:0];
    assign o_last       = last;

endmodule

### hw/rtl/crsf_frame_receiver.sv
// Frame receiver for a serial remote-control link.
// Input channel: one received byte per item on i_rx_byte with i_valid / o_stall.
// The parser hunts for the device address, then takes length, type, payload and
// a crc byte. A good channel frame gives NUM_CHANNELS results (11-bit values,
// kind 0), a good statistics frame gives 10 results (raw bytes, kind 1); o_last
// marks the final result of a frame. Other frames give nothing.
// Output channel: o_valid with i_stall from the receiver, one result per item.
// Throughput: one byte per cycle while o_stall is low. The first result of a
// frame appears in the cycle after its crc byte is accepted, and one result
// leaves per cycle while i_stall is low. Results drain from a snapshot register,
// so the next frame's bytes keep flowing; only a crc byte is held off (o_stall
// high) while the previous frame's results are still draining.
// When the receiver stalls, the current result holds until it is taken.
// Reset (synchronous, active low) returns the parser to address hunting, drops
// any pending results and restores the configuration registers to defaults.
// Configuration uses an APB-style port, register i at byte address 4*i.
module crsf_frame_receiver #(
    parameter int unsigned PAYLOAD_BYTES   = 22,
    parameter int unsigned MAX_FRAME_BYTES = 64,
    parameter int unsigned NUM_CHANNELS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    input  logic [7:0]  i_rx_byte,
    output logic        o_stall,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [3:0]  o_item_index,
    output logic [10:0] o_item_value,
    output logic        o_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import crsf_pkg::*;

    localparam int unsigned CH_BYTES = (NUM_CHANNELS * CHAN_BITS + 7) / 8;
    localparam int unsigned NEED     = (CH_BYTES > STATS_BYTES) ? CH_BYTES : STATS_BYTES;

    t_cfg              r_cfg;
    t_emit_req         req;
    logic [NEED*8-1:0] snap;
    logic              out_busy;
    logic              cfg_wr;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address  <= RST_DEVICE_ADDRESS;
            r_cfg.channels_type   <= RST_CHANNELS_TYPE;
            r_cfg.channels_length <= RST_CHANNELS_LENGTH;
            r_cfg.stats_type      <= RST_STATS_TYPE;
            r_cfg.stats_length    <= RST_STATS_LENGTH;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_DEVICE_ADDRESS:  r_cfg.device_address  <= pwdata[7:0];
                REG_CHANNELS_TYPE:   r_cfg.channels_type   <= pwdata[7:0];
                REG_CHANNELS_LENGTH: r_cfg.channels_length <= pwdata[5:0];
                REG_STATS_TYPE:      r_cfg.stats_type      <= pwdata[7:0];
                REG_STATS_LENGTH:    r_cfg.stats_length    <= pwdata[5:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[4:2])
            REG_DEVICE_ADDRESS:  prdata = {24'd0, r_cfg.device_address};
            REG_CHANNELS_TYPE:   prdata = {24'd0, r_cfg.channels_type};
            REG_CHANNELS_LENGTH: prdata = {26'd0, r_cfg.channels_length};
            REG_STATS_TYPE:      prdata = {24'd0, r_cfg.stats_type};
            REG_STATS_LENGTH:    prdata = {26'd0, r_cfg.stats_length};
            default:             prdata = 32'd0;
        endcase
    end

    // byte parser and crc
    crsf_parser #(
        .PAYLOAD_BYTES   (PAYLOAD_BYTES),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .NUM_CHANNELS    (NUM_CHANNELS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_rx_byte  (i_rx_byte),
        .i_cfg      (r_cfg),
        .i_out_busy (out_busy),
        .o_stall    (o_stall),
        .o_req      (req),
        .o_snap     (snap)
    );

    // result emitter
    crsf_emitter #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_snap       (snap),
        .i_stall      (i_stall),
        .o_busy       (out_busy),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_item_index (o_item_index),
        .o_item_value (o_item_value),
        .o_last       (o_last)
    );

endmodule

### tb/sv/crsf_frame_receiver_test.sv
module crsf_frame_receiver_test;

    timeunit 1ns;
    timeprecision 1ps;

    import crsf_pkg::*;

    localparam int unsigned PAYLOAD_BYTES   = 22;
    localparam int unsigned MAX_FRAME_BYTES = 64;
    localparam int unsigned NUM_CHANNELS    = 16;

    localparam int          CLK_PERIOD   = 10;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          QUIET_LIMIT  = 2000;
    localparam int          MAX_PRINTED  = 40;

    // register slots past the end of the list, writes there must be ignored
    localparam logic [2:0]  REG_SPARE_LO = 3'd5;
    localparam logic [2:0]  REG_SPARE_HI = 3'd7;

    // a type code that matches neither frame kind at reset
    localparam logic [7:0]  ODD_TYPE = 8'h55;

    // one result item as the output channel carries it
    typedef struct packed {
        logic        kind;
        logic [3:0]  slot;
        logic [10:0] value;
        logic        last;
    } t_item_result;

    // one frame to send, optionally with its outcome written down by hand
    typedef struct {
        logic [7:0]  addr;
        logic [7:0]  len;
        logic [7:0]  ftype;
        int          fill;
        bit          bad_crc;
        bit          pinned;
        logic        kind;
        int          count;
        logic [10:0] fixed;
    } t_frame_row;

    // one serial byte waiting to go out
    typedef struct {
        logic [7:0]  value;
        bit          pinned;
        logic        kind;
        int          count;
        logic [10:0] fixed;
    } t_serial;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_stall;
    logic        o_valid;
    logic        i_stall   = 1'b0;
    logic        o_kind;
    logic [3:0]  o_item_index;
    logic [10:0] o_item_value;
    logic        o_last;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [4:0]  paddr     = 5'd0;
    logic [31:0] pwdata    = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    crsf_frame_receiver #(
        .PAYLOAD_BYTES   (PAYLOAD_BYTES),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .NUM_CHANNELS    (NUM_CHANNELS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_rx_byte    (i_rx_byte),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_item_index (o_item_index),
        .o_item_value (o_item_value),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // parser mirror and register copy
    t_cfg         cfg;
    t_phase       rx_phase;
    logic [7:0]   rx_count;
    logic [7:0]   rx_len;
    logic [7:0]   rx_type;
    logic [7:0]   rx_crc;
    logic [7:0]   rx_payload [PAYLOAD_BYTES];

    t_item_result fresh_results[$];
    t_item_result pending_results[$];
    t_serial      serial_bytes[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;
    int mismatches    = 0;
    int bytes_queued  = 0;
    int bytes_taken   = 0;
    int frames_queued = 0;
    int results_seen  = 0;
    int frames_closed = 0;

    t_frame_row frame_rows [15];

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    // crc-8 poly 0xd5, msb first
    function automatic logic [7:0] crc_d5_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8) begin
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    // payload byte of the current frame, zero past what was received or stored
    function automatic logic [7:0] held_byte(input int i);
        if (i >= int'(rx_len) - 2 || i >= int'(PAYLOAD_BYTES)) begin
            return 8'h00;
        end
        return rx_payload[i];
    endfunction

    // advance the parser mirror by one byte, results land in fresh_results
    function automatic void decode_byte(input logic [7:0] b);
        logic [8*PAYLOAD_BYTES-1:0] bits;
        fresh_results.delete();
        case (rx_phase)
            PH_HUNT: begin
                if (b == cfg.device_address) rx_phase = PH_LEN;
            end
            PH_LEN: begin
                if (b < 2 || int'(b) > int'(MAX_FRAME_BYTES) - 2) begin
                    rx_phase = PH_HUNT;
                end else begin
                    rx_len   = b;
                    rx_count = 8'd0;
                    rx_crc   = 8'd0;
                    rx_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                rx_type  = b;
                rx_crc   = crc_d5_step(8'h00, b);
                rx_phase = (rx_len > 2) ? PH_PAYLOAD : PH_CRC;
            end
            PH_PAYLOAD: begin
                if (rx_count < PAYLOAD_BYTES) rx_payload[rx_count] = b;
                rx_crc   = crc_d5_step(rx_crc, b);
                rx_count = rx_count + 8'd1;
                if (rx_count >= rx_len - 8'd2) rx_phase = PH_CRC;
            end
            PH_CRC: begin
                if (b == rx_crc) begin
                    if (rx_type == cfg.channels_type && rx_len == {2'b00, cfg.channels_length}) begin
                        for (int i = 0; i < int'(PAYLOAD_BYTES); i++) begin
                            bits[8*i +: 8] = held_byte(i);
                        end
                        for (int c = 0; c < int'(NUM_CHANNELS); c++) begin
                            fresh_results.push_back(t_item_result'{KIND_CHANNEL, 4'(c),
                                bits[c*CHAN_BITS +: CHAN_BITS], c == int'(NUM_CHANNELS) - 1});
                        end
                    end else if (rx_type == cfg.stats_type &&
                                 rx_len == {2'b00, cfg.stats_length}) begin
                        for (int i = 0; i < int'(STATS_BYTES); i++) begin
                            fresh_results.push_back(t_item_result'{KIND_STATS, 4'(i),
                                {3'b000, held_byte(i)}, i == int'(STATS_BYTES) - 1});
                        end
                    end
                end
                rx_phase = PH_HUNT;
            end
            default: rx_phase = PH_HUNT;
        endcase
    endfunction

    function automatic void store_setting(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            REG_DEVICE_ADDRESS:  cfg.device_address  = data[7:0];
            REG_CHANNELS_TYPE:   cfg.channels_type   = data[7:0];
            REG_CHANNELS_LENGTH: cfg.channels_length = data[5:0];
            REG_STATS_TYPE:      cfg.stats_type      = data[7:0];
            REG_STATS_LENGTH:    cfg.stats_length    = data[5:0];
            default: ;
        endcase
    endfunction

    // sender: accept, predict, then present the next byte or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                bytes_taken++;
                decode_byte(i_rx_byte);
                if (serial_bytes[0].pinned) begin
                    for (int k = 0; k < serial_bytes[0].count; k++) begin
                        pending_results.push_back(t_item_result'{serial_bytes[0].kind, 4'(k),
                            serial_bytes[0].fixed, k == serial_bytes[0].count - 1});
                    end
                end else begin
                    foreach (fresh_results[k]) pending_results.push_back(fresh_results[k]);
                end
                void'(serial_bytes.pop_front());
            end
            if (!(i_valid && o_stall)) begin
                if (serial_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_valid   <= 1'b1;
                    i_rx_byte <= serial_bytes[0].value;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_result();
        t_item_result want;
        results_seen++;
        if (o_last) frames_closed++;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d index %0d value %0d last %0d",
                o_kind, o_item_index, o_item_value, o_last));
            return;
        end
        want = pending_results.pop_front();
        if (o_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", o_kind, want.kind));
        if (o_item_index !== want.slot)
            report_mismatch($sformatf("index %0d, want %0d", o_item_index, want.slot));
        if (o_item_value !== want.value)
            report_mismatch($sformatf("value %0d, want %0d (index %0d)",
                o_item_value, want.value, want.slot));
        if (o_last !== want.last)
            report_mismatch($sformatf("last %0d, want %0d (index %0d)",
                o_last, want.last, want.slot));
    endtask

    // receiver: check taken results, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) check_result();
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // count cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("crsf_frame_receiver regression: fail");
        $finish;
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        store_setting(idx, data);
    endtask

    task automatic reg_check(input logic [2:0] idx);
        logic [31:0] got;
        logic [31:0] want;
        logic [31:0] mask;
        case (idx)
            REG_DEVICE_ADDRESS:  begin want = 32'(cfg.device_address);  mask = 32'hFF; end
            REG_CHANNELS_TYPE:   begin want = 32'(cfg.channels_type);   mask = 32'hFF; end
            REG_CHANNELS_LENGTH: begin want = 32'(cfg.channels_length); mask = 32'h3F; end
            REG_STATS_TYPE:      begin want = 32'(cfg.stats_type);      mask = 32'hFF; end
            default:             begin want = 32'(cfg.stats_length);    mask = 32'h3F; end
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        got = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((got & mask) !== want)
            report_mismatch($sformatf("register %0d reads %0h, want %0h", idx, got & mask, want));
    endtask

    // optionally fill the unused upper bits with junk
    function automatic logic [31:0] pad_upper(input logic [31:0] val, input int w, input bit noisy);
        if (!noisy) return val;
        return ($urandom() << w) | val;
    endfunction

    task automatic program_settings(input logic [7:0] addr, input logic [7:0] ch_type,
                                    input logic [5:0] ch_len, input logic [7:0] st_type,
                                    input logic [5:0] st_len, input bit noisy);
        reg_write(REG_DEVICE_ADDRESS, pad_upper(32'(addr), 8, noisy));
        reg_write(REG_CHANNELS_TYPE, pad_upper(32'(ch_type), 8, noisy));
        reg_write(REG_CHANNELS_LENGTH, pad_upper(32'(ch_len), 6, noisy));
        reg_write(REG_STATS_TYPE, pad_upper(32'(st_type), 8, noisy));
        reg_write(REG_STATS_LENGTH, pad_upper(32'(st_len), 6, noisy));
        reg_check(REG_DEVICE_ADDRESS);
        reg_check(REG_CHANNELS_TYPE);
        reg_check(REG_CHANNELS_LENGTH);
        reg_check(REG_STATS_TYPE);
        reg_check(REG_STATS_LENGTH);
    endtask

    task automatic queue_byte(input logic [7:0] value, input bit pinned, input t_frame_row row);
        serial_bytes.push_back(t_serial'{value, pinned, row.kind, row.count, row.fixed});
        bytes_queued++;
    endtask

    // address, length, type, payload, crc; a bad length ends the frame early
    task automatic push_frame(input t_frame_row row);
        logic [7:0] crc;
        logic [7:0] b;
        frames_queued++;
        queue_byte(row.addr, 1'b0, row);
        if (row.len < 2 || int'(row.len) > int'(MAX_FRAME_BYTES) - 2) begin
            queue_byte(row.len, row.pinned, row);
            return;
        end
        queue_byte(row.len, 1'b0, row);
        crc = crc_d5_step(8'h00, row.ftype);
        queue_byte(row.ftype, 1'b0, row);
        for (int i = 0; i < int'(row.len) - 2; i++) begin
            b   = (row.fill < 0) ? 8'($urandom_range(0, 255)) : 8'(row.fill);
            crc = crc_d5_step(crc, b);
            queue_byte(b, 1'b0, row);
        end
        if (row.bad_crc) crc = crc ^ (8'h01 << $urandom_range(0, 7));
        queue_byte(crc, row.pinned, row);
    endtask

    // mostly well-formed frames for the current settings, the rest broken or noise
    task automatic queue_random_frame();
        t_frame_row row;
        int         pick;
        row  = '{cfg.device_address, {2'b00, cfg.channels_length}, cfg.channels_type,
                 -1, 1'b0, 1'b0, KIND_CHANNEL, 0, 11'd0};
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            push_frame(row);
        end else if (pick < 65) begin
            row.len   = {2'b00, cfg.stats_length};
            row.ftype = cfg.stats_type;
            push_frame(row);
        end else if (pick < 73) begin
            if ($urandom_range(0, 1) == 1) begin
                row.len   = {2'b00, cfg.stats_length};
                row.ftype = cfg.stats_type;
            end
            row.bad_crc = 1'b1;
            push_frame(row);
        end else if (pick < 80) begin
            row.ftype = 8'($urandom_range(0, 255));
            row.len   = 8'($urandom_range(2, 20));
            push_frame(row);
        end else if (pick < 85) begin
            row.len = 8'($urandom_range(2, MAX_FRAME_BYTES - 2));
            push_frame(row);
        end else if (pick < 90) begin
            row.len = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 1))
                                                  : 8'($urandom_range(MAX_FRAME_BYTES - 1, 255));
            push_frame(row);
        end else begin
            repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)), 1'b0, row);
        end
    endtask

    // wait until every byte is in and every result is out
    task automatic settle();
        while (serial_bytes.size() != 0 || i_valid || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 68; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 68; end
            default: begin send_idle_pct = 21; stall_pct = 21; end
        endcase
    endtask

    initial begin
        int start_bytes;

        // register copy and parser mirror at reset
        cfg = '{RST_DEVICE_ADDRESS, RST_CHANNELS_TYPE, RST_CHANNELS_LENGTH,
                RST_STATS_TYPE, RST_STATS_LENGTH};
        rx_phase = PH_HUNT;
        rx_count = 8'd0;
        rx_len   = 8'd0;
        rx_type  = 8'd0;
        rx_crc   = 8'd0;
        foreach (rx_payload[i]) rx_payload[i] = 8'h00;

        // directed frames at reset settings; fill -1 means random payload
        frame_rows = '{
            // all-zero and all-one channel payloads
            '{RST_DEVICE_ADDRESS, RST_CHANNELS_LENGTH, RST_CHANNELS_TYPE, 0, 0, 1,
              KIND_CHANNEL, 16, 11'd0},
            '{RST_DEVICE_ADDRESS, RST_CHANNELS_LENGTH, RST_CHANNELS_TYPE, 255, 0, 1,
              KIND_CHANNEL, 16, 11'd2047},
            // statistics extremes
            '{RST_DEVICE_ADDRESS, RST_STATS_LENGTH, RST_STATS_TYPE, 255, 0, 1,
              KIND_STATS, 10, 11'd255},
            '{RST_DEVICE_ADDRESS, RST_STATS_LENGTH, RST_STATS_TYPE, 0, 0, 1,
              KIND_STATS, 10, 11'd0},
            // bad crc on each kind
            '{RST_DEVICE_ADDRESS, RST_CHANNELS_LENGTH, RST_CHANNELS_TYPE, -1, 1, 1,
              KIND_CHANNEL, 0, 11'd0},
            '{RST_DEVICE_ADDRESS, RST_STATS_LENGTH, RST_STATS_TYPE, -1, 1, 1,
              KIND_STATS, 0, 11'd0},
            // unknown type, and a known type with the wrong length
            '{RST_DEVICE_ADDRESS, RST_STATS_LENGTH, ODD_TYPE, -1, 0, 1, KIND_CHANNEL, 0, 11'd0},
            '{RST_DEVICE_ADDRESS, RST_CHANNELS_LENGTH, RST_STATS_TYPE, -1, 0, 1,
              KIND_CHANNEL, 0, 11'd0},
            // length bytes out of range
            '{RST_DEVICE_ADDRESS, 8'd1, 8'd0, 0, 0, 1, KIND_CHANNEL, 0, 11'd0},
            '{RST_DEVICE_ADDRESS, 8'd0, 8'd0, 0, 0, 1, KIND_CHANNEL, 0, 11'd0},
            '{RST_DEVICE_ADDRESS, 8'd63, 8'd0, 0, 0, 1, KIND_CHANNEL, 0, 11'd0},
            '{RST_DEVICE_ADDRESS, 8'd255, 8'd0, 0, 0, 1, KIND_CHANNEL, 0, 11'd0},
            // type byte only, then the longest length the parser accepts
            '{RST_DEVICE_ADDRESS, 8'd2, RST_CHANNELS_TYPE, 0, 0, 1, KIND_CHANNEL, 0, 11'd0},
            '{RST_DEVICE_ADDRESS, 8'd62, RST_CHANNELS_TYPE, -1, 0, 1, KIND_CHANNEL, 0, 11'd0},
            // bytes for some other address
            '{8'd0, RST_STATS_LENGTH, RST_STATS_TYPE, 85, 0, 1, KIND_CHANNEL, 0, 11'd0}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, back to back
        set_idling(0);
        foreach (frame_rows[r]) push_frame(frame_rows[r]);
        settle();

        // random part over several register settings
        for (int p = 0; p < 6; p++) begin
            settle();
            set_idling(0);
            case (p)
                0: begin
                    program_settings(8'd0, 8'd0, 6'd2, 8'd255, 6'd62, 1'b0);
                    reg_write(REG_SPARE_LO, $urandom());
                    reg_write(REG_SPARE_HI, $urandom());
                end
                1: program_settings(8'd255, 8'd255, 6'd62, 8'd0, 6'd2, 1'b0);
                // both kinds share a type code, channels win on equal length
                2: program_settings(RST_DEVICE_ADDRESS, 8'h7F, 6'd5, 8'h7F,
                                    ($urandom_range(0, 1) == 1) ? 6'd5 : 6'd8, 1'b0);
                3, 4: program_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                       6'($urandom_range(2, 30)), 8'($urandom_range(0, 255)),
                                       6'($urandom_range(2, 30)), 1'b1);
                default: program_settings(RST_DEVICE_ADDRESS, RST_CHANNELS_TYPE,
                                          RST_CHANNELS_LENGTH, RST_STATS_TYPE,
                                          RST_STATS_LENGTH, 1'b0);
            endcase
            set_idling(p % 4);
            start_bytes = bytes_queued;
            while (bytes_queued - start_bytes < 12) begin
                queue_random_frame();
                // one phase holds each frame back until the last one has drained
                if (p == 2) begin
                    settle();
                end else begin
                    while (serial_bytes.size() > 8) @(posedge i_clk);
                end
            end
        end

        settle();
        repeat (4 * DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("sent %0d bytes in %0d frames over six register settings and four idle patterns",
                 bytes_taken, frames_queued);
        $display("checked %0d results closing %0d frames, %0d mismatches",
                 results_seen, frames_closed, mismatches);
        if (mismatches == 0) begin
            $display("crsf_frame_receiver regression: pass");
        end else begin
            $display("crsf_frame_receiver regression: fail");
        end
        $finish;
    end

endmodule
